// ----- design/keq_pkg.sv -----
// Shared types and constants for the key event queue.
`default_nettype none

package keq_pkg;

  localparam int unsigned QueueDepth = 32;
  localparam int unsigned PtrW       = $clog2(QueueDepth);
  localparam int unsigned KeyW       = 8;
  localparam int unsigned NumKeys    = 1 << KeyW;

  typedef enum logic {
    OpKeyChange = 1'b0,
    OpGetEvent  = 1'b1
  } op_e;

  typedef logic [PtrW-1:0] ptr_t;

  typedef struct packed {
    logic pressed;
    logic [KeyW-1:0] key;
  } event_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;     // input transfer: latch the item and start memory reads
    logic update_key;  // record the new key state and queue an event
    logic pop;         // answer a request into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_request;
    logic key_changed;
    logic out_blocked;
  } status_t;

endpackage

`default_nettype wire

// ----- design/keq_ctrl.sv -----
// Controller state machine for the key event queue.
`default_nettype none

module keq_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire keq_pkg::status_t status_i,
  output keq_pkg::cmd_t         cmd_o
);

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StExec = 2'b10
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    in_stall_o     = 1'b1;
    unique case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StExec;
        end
      end
      StExec: begin
        if (status_i.is_request) begin
          // Hold the request until the output register can take its result.
          if (!status_i.out_blocked) begin
            cmd_o.pop = 1'b1;
            state_d   = StIdle;
          end
        end else begin
          cmd_o.update_key = status_i.key_changed;
          state_d          = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/keq_dp.sv -----
// Datapath of the key event queue: key state store, event ring and output register.
`default_nettype none

module keq_dp (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [0:0]                opcode_i,
  input  wire logic [keq_pkg::KeyW-1:0]  key_code_i,
  input  wire logic                      pressed_i,
  input  wire keq_pkg::cmd_t             cmd_i,
  output keq_pkg::status_t               status_o,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic                           got_event_o,
  output logic                           event_pressed_o,
  output logic [keq_pkg::KeyW-1:0]       event_key_o
);

  // Latched item.
  logic [0:0]               opcode_q;
  logic [keq_pkg::KeyW-1:0] key_q;
  logic                     pressed_q;

  // Key state memory; an entry that was never written reads as up.
  logic                     key_mem [keq_pkg::NumKeys];
  logic                     key_rdata_q;
  logic [keq_pkg::NumKeys-1:0] key_vld_q;

  // Event ring.
  keq_pkg::event_t          ev_mem [keq_pkg::QueueDepth];
  keq_pkg::event_t          ev_rdata_q;
  keq_pkg::ptr_t            wr_ptr_q, wr_ptr_d;
  keq_pkg::ptr_t            rd_ptr_q, rd_ptr_d;

  // Output register.
  logic                     out_valid_q;
  logic                     got_q;
  keq_pkg::event_t          out_ev_q;

  logic                     cur_down;
  logic                     empty;

  function automatic keq_pkg::ptr_t advance(input keq_pkg::ptr_t p);
    if (p == keq_pkg::PtrW'(keq_pkg::QueueDepth - 1)) begin
      return '0;
    end
    return p + keq_pkg::PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      opcode_q    <= opcode_i;
      key_q       <= key_code_i;
      pressed_q   <= pressed_i;
      key_rdata_q <= key_mem[key_code_i];
      ev_rdata_q  <= ev_mem[rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update_key) begin
      key_mem[key_q]   <= pressed_q;
      ev_mem[wr_ptr_q] <= '{pressed: pressed_q, key: key_q};
    end
  end

  assign cur_down = key_vld_q[key_q] & key_rdata_q;
  assign empty    = (rd_ptr_q == wr_ptr_q);

  assign status_o.is_request  = (opcode_q == keq_pkg::OpGetEvent);
  assign status_o.key_changed = (cur_down != pressed_q);
  assign status_o.out_blocked = out_valid_q & out_stall_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (cmd_i.update_key) begin
      wr_ptr_d = advance(wr_ptr_q);
    end
    if (cmd_i.pop && !empty) begin
      rd_ptr_d = advance(rd_ptr_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_vld_q   <= '0;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.update_key) begin
        key_vld_q[key_q] <= 1'b1;
      end
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      if (cmd_i.pop) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pop) begin
      got_q    <= !empty;
      out_ev_q <= empty ? '0 : ev_rdata_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign got_event_o     = got_q;
  assign event_pressed_o = out_ev_q.pressed;
  assign event_key_o     = out_ev_q.key;

endmodule

`default_nettype wire

// ----- design/key_event_queue.sv -----
// Key event queue top level: controller and datapath.
//
// Each item is first transferred in while the key state and ring memories are
// read, then compared, with the key state updated and the pointers advanced.
// A request whose result cannot enter the output register waits in the
// execute state until the output side takes the previous result. Key change
// reports that do not alter a key's recorded state are dropped silently and
// produce no result; requests always produce one, with got_event low when the
// queue is empty. The ring has no full check: once its depth of events go
// unread, the queue reads as empty. Key state starts as all up after reset,
// with no clearing pass.
`default_nettype none

module key_event_queue (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [0:0]                opcode_i,
  input  wire logic [keq_pkg::KeyW-1:0]  key_code_i,
  input  wire logic                      pressed_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic                           got_event_o,
  output logic                           event_pressed_o,
  output logic [keq_pkg::KeyW-1:0]       event_key_o
);

  keq_pkg::cmd_t    cmd;
  keq_pkg::status_t status;

  keq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  keq_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .opcode_i        (opcode_i),
    .key_code_i      (key_code_i),
    .pressed_i       (pressed_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .got_event_o     (got_event_o),
    .event_pressed_o (event_pressed_o),
    .event_key_o     (event_key_o)
  );

endmodule

`default_nettype wire
